### src/kfd_pkg.sv
package kfd_pkg;

    // Frame capacity ceiling and derived widths
    localparam int unsigned MAX_FRAME = 4096;
    localparam int unsigned LEN_W     = 13;
    localparam int unsigned DROP_W    = 32;

    // KISS special bytes
    localparam logic [7:0] FEND  = 8'hC0;
    localparam logic [7:0] FESC  = 8'hDB;
    localparam logic [7:0] TFEND = 8'hDC;
    localparam logic [7:0] TFESC = 8'hDD;

    // Command nibbles
    localparam logic [3:0] CMD_DATA     = 4'd0;
    localparam logic [3:0] CMD_LAST_STD = 4'd6;
    localparam logic [3:0] CMD_RETURN   = 4'd15;

    localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(MAX_FRAME);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_COMMAND,
        MODE_BODY,
        MODE_ESCAPE
    } kfd_mode_t;

    typedef struct packed {
        logic              data_valid;
        logic [7:0]        data_byte;
        logic [3:0]        frame_port;
        logic              frame_done;
        logic [LEN_W-1:0]  frame_length;
        logic              protocol_error;
        logic              frame_dropped;
        logic [DROP_W-1:0] drop_total;
    } kfd_result_t;

endpackage

### src/kiss_frame_deframer.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  rx_byte
// result    out        out_valid/out_stall  data_valid .. drop_total
// config    in         cfg_valid/cfg_ready  cfg_data (max_frame_len)
//
// One byte per cycle while not stalled; each result is registered in the buffer.
// The parser state updates in the same cycle a byte is accepted, so bytes
// may follow back to back. A two-slot result buffer absorbs out_stall;
// in_stall rises only when both slots are full.
// rst_n clears parser state, the drop count and the buffer; limit resets to 4096.
module kiss_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        data_valid,
    output logic [7:0]  data_byte,
    output logic [3:0]  frame_port,
    output logic        frame_done,
    output logic [12:0] frame_length,
    output logic        protocol_error,
    output logic        frame_dropped,
    output logic [31:0] drop_total
);
    import kfd_pkg::*;

    logic        accept;
    logic        buf_full;
    kfd_result_t step_result;
    kfd_result_t head;

    assign cfg_ready = 1'b1;
    assign in_stall  = buf_full;
    assign accept    = in_valid && !buf_full;

    // Parse one byte per transaction
    kfd_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (accept),
        .rx_byte  (rx_byte),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .result   (step_result)
    );

    // Register results toward the output channel
    kfd_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (step_result),
        .full       (buf_full),
        .head_valid (out_valid),
        .head_stall (out_stall),
        .head_data  (head)
    );

    assign data_valid     = head.data_valid;
    assign data_byte      = head.data_byte;
    assign frame_port     = head.frame_port;
    assign frame_done     = head.frame_done;
    assign frame_length   = head.frame_length;
    assign protocol_error = head.protocol_error;
    assign frame_dropped  = head.frame_dropped;
    assign drop_total     = head.drop_total;

endmodule

### src/kfd_parser.sv
module kfd_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            rx_byte,
    input  logic                  cfg_we,
    input  logic [12:0]           cfg_data,
    output kfd_pkg::kfd_result_t  result
);
    import kfd_pkg::*;

    kfd_mode_t         mode_reg, mode_next;
    logic [3:0]        cmd_reg, cmd_next;
    logic [3:0]        port_reg, port_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [DROP_W-1:0] drops_reg, drops_next;
    logic [LEN_W-1:0]  limit_reg;

    logic [LEN_W-1:0]  limit_eff;
    logic              drop;
    kfd_mode_t         mode_cur;
    logic [3:0]        cmd_cur;
    logic [3:0]        port_cur;
    logic [LEN_W-1:0]  count_cur;
    logic [3:0]        nib;
    logic              cmd_known;

    // Hold the frame capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_data;
        end
    end

    // Advance parser state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            cmd_reg   <= CMD_RETURN;
            port_reg  <= '0;
            count_reg <= '0;
            drops_reg <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            cmd_reg   <= cmd_next;
            port_reg  <= port_next;
            count_reg <= count_next;
            drops_reg <= drops_next;
        end
    end

    // Clamp the limit into 1..MAX_FRAME
    always_comb
    begin
        if (limit_reg == '0)
        begin
            limit_eff = LEN_W'(1);
        end
        else if (limit_reg > LIMIT_RESET)
        begin
            limit_eff = LIMIT_RESET;
        end
        else
        begin
            limit_eff = limit_reg;
        end
    end

    assign nib       = rx_byte[3:0];
    assign cmd_known = (nib <= CMD_LAST_STD) || (nib == CMD_RETURN);

    // Drop an overlong frame first, then parse the byte
    always_comb
    begin
        drop      = (count_reg >= limit_eff);
        mode_cur  = drop ? MODE_IDLE : mode_reg;
        cmd_cur   = drop ? CMD_RETURN : cmd_reg;
        port_cur  = drop ? 4'd0 : port_reg;
        count_cur = drop ? '0 : count_reg;

        mode_next  = mode_cur;
        cmd_next   = cmd_cur;
        port_next  = port_cur;
        count_next = count_cur;
        drops_next = drops_reg + DROP_W'(drop);

        result                = '0;
        result.frame_dropped  = drop;

        case (mode_cur)
            MODE_IDLE:
            begin
                if (rx_byte == FEND)
                begin
                    mode_next = MODE_COMMAND;
                end
            end
            MODE_COMMAND:
            begin
                if (rx_byte != FEND)
                begin
                    if (cmd_known)
                    begin
                        cmd_next  = nib;
                        port_next = rx_byte[7:4];
                        mode_next = MODE_BODY;
                    end
                    else
                    begin
                        result.protocol_error = 1'b1;
                    end
                end
            end
            MODE_BODY:
            begin
                if (rx_byte == FESC)
                begin
                    mode_next = MODE_ESCAPE;
                end
                else if (rx_byte == FEND)
                begin
                    // deliver a non-empty data frame for port 0, discard others
                    if (cmd_cur == CMD_DATA && port_cur == 4'd0 && count_cur != '0)
                    begin
                        result.frame_done   = 1'b1;
                        result.frame_length = count_cur;
                        mode_next           = MODE_IDLE;
                    end
                    else
                    begin
                        mode_next = MODE_COMMAND;
                    end
                    count_next = '0;
                    cmd_next   = CMD_RETURN;
                end
                else if (cmd_cur == CMD_DATA)
                begin
                    result.data_valid = 1'b1;
                    result.data_byte  = rx_byte;
                    count_next        = count_cur + LEN_W'(1);
                end
            end
            MODE_ESCAPE:
            begin
                if (rx_byte == TFEND || rx_byte == TFESC)
                begin
                    if (cmd_cur == CMD_DATA)
                    begin
                        result.data_valid = 1'b1;
                        result.data_byte  = (rx_byte == TFEND) ? FEND : FESC;
                        count_next        = count_cur + LEN_W'(1);
                    end
                    mode_next = MODE_BODY;
                end
                else
                begin
                    result.protocol_error = 1'b1;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        result.frame_port = port_next;
        result.drop_total = drops_next;
    end

endmodule

### src/kfd_out_buf.sv
module kfd_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  kfd_pkg::kfd_result_t  push_data,
    output logic                  full,
    output logic                  head_valid,
    input  logic                  head_stall,
    output kfd_pkg::kfd_result_t  head_data
);
    import kfd_pkg::*;

    kfd_result_t head_reg;
    kfd_result_t skid_reg;
    logic        head_valid_reg;
    logic        skid_valid_reg;
    logic        pop;

    assign pop        = head_valid_reg && !head_stall;
    assign full       = skid_valid_reg;
    assign head_valid = head_valid_reg;
    assign head_data  = head_reg;

    // Track occupancy of the head and skid slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                head_valid_reg <= push;
            end
        end
        else if (head_valid_reg)
        begin
            if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else
        begin
            head_valid_reg <= push;
        end
    end

    // Move payloads: refill head from skid, else park new results
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            head_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (head_valid_reg)
        begin
            if (push)
            begin
                skid_reg <= push_data;
            end
        end
        else
        begin
            head_reg <= push_data;
        end
    end

endmodule

### src/kfd_checker.sv
module kfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        data_valid,
    input logic [7:0]  data_byte,
    input logic [3:0]  frame_port,
    input logic        frame_done,
    input logic [12:0] frame_length,
    input logic        protocol_error,
    input logic        frame_dropped,
    input logic [31:0] drop_total
);

    // Stall only while results are waiting
    a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall high with no pending result");

    // No result appears without a transaction in
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !(in_valid && !in_stall)) |=> !out_valid)
        else $error("result appeared without an accepted byte");

    // Delivered frame is non-empty, on port 0, with no payload byte alongside
    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |->
            (frame_length != 13'd0 && frame_port == 4'd0 && !data_valid && !protocol_error))
        else $error("malformed frame delivery");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(data_byte) && $stable(drop_total)
             && $stable(frame_length) && $stable(frame_dropped)))
        else $error("stalled result changed");

endmodule

bind kiss_frame_deframer kfd_checker u_kfd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data_valid     (data_valid),
    .data_byte      (data_byte),
    .frame_port     (frame_port),
    .frame_done     (frame_done),
    .frame_length   (frame_length),
    .protocol_error (protocol_error),
    .frame_dropped  (frame_dropped),
    .drop_total     (drop_total)
);
